@@ rtl/core/sqw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqw_pkg: shared types and constants of the square-wave channel
// Command and register codes, configuration and result records, duty table.
// ----------------------------------------------------------------------------
package sqw_pkg;

  localparam int unsigned HAS_SWEEP_DEFAULT = 1;

  localparam int unsigned PERIOD_W = 11;
  localparam int unsigned TICK_W   = 14;
  localparam int unsigned LEVEL_W  = 4;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned INDEX_W  = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_LIMIT = 11'd2047;
  localparam logic [PERIOD_W:0]   PERIOD_BASE  = 12'd2048;

  typedef enum logic [1:0] {
    CMD_CLOCK   = 2'd0,
    CMD_SWEEP   = 2'd1,
    CMD_TRIGGER = 2'd2,
    CMD_LENGTH  = 2'd3
  } sqw_cmd_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_DUTY_SELECT    = 3'd0,
    REG_PERIOD_VALUE   = 3'd1,
    REG_SWEEP_PERIOD   = 3'd2,
    REG_SWEEP_DECREASE = 3'd3,
    REG_SWEEP_SHIFT    = 3'd4
  } sqw_reg_t;

  typedef struct packed {
    logic [1:0]          duty_select;
    logic [PERIOD_W-1:0] period_value;
    logic [2:0]          sweep_period;
    logic                sweep_decrease;
    logic [2:0]          sweep_shift;
  } sqw_cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  sample;
    logic                active;
    logic [PERIOD_W-1:0] current_period;
  } sqw_result_t;

  function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
    logic [7:0] pat;
    unique case (sel)
      2'd0:    pat = 8'b0000_0001;
      2'd1:    pat = 8'b1000_0001;
      2'd2:    pat = 8'b1000_0111;
      default: pat = 8'b0111_1110;
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/core/sqw_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqw_step: channel state and single-pass update
// Holds timer, duty position, sweep counter, period, enable and sample level;
// computes the state after one command and commits it on each transfer.
// ----------------------------------------------------------------------------
module sqw_step #(
  parameter int unsigned HAS_SWEEP = sqw_pkg::HAS_SWEEP_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [1:0]                    cmd,
  input  logic [sqw_pkg::LEVEL_W-1:0]   volume,
  input  sqw_pkg::sqw_cfg_t             cfg,
  output sqw_pkg::sqw_result_t          result_next
);

  logic [sqw_pkg::PERIOD_W-1:0] period_now, period_now_next;
  logic [sqw_pkg::TICK_W-1:0]   tick_count, tick_count_next;
  logic [2:0]                   duty_step, duty_step_next;
  logic [2:0]                   sweep_elapsed, sweep_elapsed_next;
  logic                         enabled, enabled_next;
  logic [sqw_pkg::LEVEL_W-1:0]  sample_level, sample_level_next;

  sqw_pkg::sqw_cmd_t            op;
  logic [sqw_pkg::TICK_W-1:0]   limit;
  logic [sqw_pkg::TICK_W-1:0]   tick_inc;
  logic [2:0]                   duty_inc;
  logic [2:0]                   elapsed_inc;
  logic [sqw_pkg::PERIOD_W-1:0] change;
  logic [sqw_pkg::PERIOD_W:0]   sum;
  logic                         sweep_on;
  logic [7:0]                   pattern;

  assign op       = sqw_pkg::sqw_cmd_t'(cmd);
  assign limit    = {sqw_pkg::PERIOD_BASE - {1'b0, period_now}, 2'b00};
  assign tick_inc = tick_count + 1'b1;
  assign duty_inc = duty_step + 1'b1;
  assign pattern  = sqw_pkg::duty_pattern(cfg.duty_select);
  assign sweep_on = (HAS_SWEEP != 0) && (cfg.sweep_period != 3'd0);
  assign elapsed_inc = (sweep_elapsed != cfg.sweep_period) ? sweep_elapsed + 1'b1
                                                           : sweep_elapsed;
  assign change   = period_now >> cfg.sweep_shift;
  assign sum      = {1'b0, period_now} + {1'b0, change};

  always_comb begin
    period_now_next    = period_now;
    tick_count_next    = tick_count;
    duty_step_next     = duty_step;
    sweep_elapsed_next = sweep_elapsed;
    enabled_next       = enabled;
    sample_level_next  = sample_level;
    unique case (op)
      sqw_pkg::CMD_CLOCK: begin
        tick_count_next = tick_inc;
        if (tick_inc >= limit) begin
          duty_step_next    = duty_inc;
          sample_level_next = (enabled && pattern[~duty_inc]) ? volume : '0;
          tick_count_next   = tick_inc - limit;
        end
      end
      sqw_pkg::CMD_SWEEP: begin
        if (sweep_on) begin
          sweep_elapsed_next = elapsed_inc;
          if (elapsed_inc == cfg.sweep_period) begin
            if (cfg.sweep_decrease) begin
              period_now_next    = period_now - change;
              tick_count_next    = '0;
              sweep_elapsed_next = '0;
            end else if (sum > {1'b0, sqw_pkg::PERIOD_LIMIT}) begin
              enabled_next = 1'b0;
            end else begin
              period_now_next    = sum[sqw_pkg::PERIOD_W-1:0];
              tick_count_next    = '0;
              sweep_elapsed_next = '0;
            end
          end
        end
      end
      sqw_pkg::CMD_TRIGGER: begin
        enabled_next       = 1'b1;
        period_now_next    = cfg.period_value;
        tick_count_next    = '0;
        duty_step_next     = '0;
        sweep_elapsed_next = '0;
      end
      sqw_pkg::CMD_LENGTH: begin
        enabled_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_now    <= '0;
      tick_count    <= '0;
      duty_step     <= '0;
      sweep_elapsed <= '0;
      enabled       <= 1'b0;
      sample_level  <= '0;
    end else if (advance) begin
      period_now    <= period_now_next;
      tick_count    <= tick_count_next;
      duty_step     <= duty_step_next;
      sweep_elapsed <= sweep_elapsed_next;
      enabled       <= enabled_next;
      sample_level  <= sample_level_next;
    end
  end

  assign result_next.sample         = sample_level_next;
  assign result_next.active         = enabled_next;
  assign result_next.current_period = period_now_next;

`ifndef SYNTHESIS
  a_enable_by_trigger: assert property (@(posedge clk) disable iff (rst)
    $rose(enabled) |-> $past(advance && (cmd == sqw_pkg::CMD_TRIGGER)))
    else $error("channel enabled without a trigger");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(period_now) && $stable(tick_count) && $stable(sample_level))
    else $error("channel state moved without a transfer");

  a_length_stops: assert property (@(posedge clk) disable iff (rst)
    advance && (cmd == sqw_pkg::CMD_LENGTH) |=> !enabled)
    else $error("length expiry did not stop the channel");
`endif

endmodule

@@ rtl/core/square_wave_channel_with_sweep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_wave_channel_with_sweep: square-wave sound channel with sweep
// Usage:
//   Input channel (in_valid/in_ready) carries cmd and volume: clock tick,
//   sweep tick, trigger or length expiry. Each transfer yields exactly one
//   result on the output channel (out_valid/out_ready): sample, active and
//   current_period after that command.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   duty_select, period_value, sweep_period, sweep_decrease, sweep_shift at
//   indexes 0..4; other indexes are ignored. cfg_ready is always high.
//   Each result is registered into the result buffer as its command transfers.
//   Throughput: one command per cycle; the state update is a single pass of
//   one 14-bit add, compare and subtract on the frequency timer.
//   A two-entry result buffer decouples the sides: a command is still taken
//   while one result waits, and in_ready drops only when both entries are
//   full under a stalled receiver.
//   Reset clears the configuration, channel state, buffer pointers and count.
// ----------------------------------------------------------------------------
module square_wave_channel_with_sweep #(
  parameter int unsigned HAS_SWEEP = sqw_pkg::HAS_SWEEP_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [sqw_pkg::LEVEL_W-1:0]   volume,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sqw_pkg::LEVEL_W-1:0]   sample,
  output logic                          active,
  output logic [sqw_pkg::PERIOD_W-1:0]  current_period,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sqw_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [sqw_pkg::CFG_W-1:0]     cfg_data
);

  sqw_pkg::sqw_cfg_t    cfg;
  sqw_pkg::sqw_result_t result_next;
  sqw_pkg::sqw_result_t buffer [2];
  logic                 wr_ptr, rd_ptr;
  logic [1:0]           count;
  logic                 push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (sqw_pkg::sqw_reg_t'(cfg_index))
        sqw_pkg::REG_DUTY_SELECT:    cfg.duty_select    <= cfg_data[1:0];
        sqw_pkg::REG_PERIOD_VALUE:   cfg.period_value   <= cfg_data[sqw_pkg::PERIOD_W-1:0];
        sqw_pkg::REG_SWEEP_PERIOD:   cfg.sweep_period   <= cfg_data[2:0];
        sqw_pkg::REG_SWEEP_DECREASE: cfg.sweep_decrease <= cfg_data[0];
        sqw_pkg::REG_SWEEP_SHIFT:    cfg.sweep_shift    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  sqw_step #(
    .HAS_SWEEP (HAS_SWEEP)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .advance     (push),
    .cmd         (cmd),
    .volume      (volume),
    .cfg         (cfg),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (push) begin
      buffer[wr_ptr] <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign sample         = buffer[rd_ptr].sample;
  assign active         = buffer[rd_ptr].active;
  assign current_period = buffer[rd_ptr].current_period;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: square-wave channel with sweep
// A directed table walks reset state, period and volume extremes, every
// command, sweep overflow, a decrease down to zero, length stop and re-trigger.
// Random phases follow: each sets new registers while the block is idle, then
// sends triggered runs of clock, sweep, trigger and length commands. Results
// are compared field by field to a pinned row or an in-bench channel model.
// ----------------------------------------------------------------------------
module testbench;
  import sqw_pkg::*;

  localparam int unsigned SWEEP_ON       = HAS_SWEEP_DEFAULT;
  localparam int unsigned PHASES         = 16;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned PRINT_LIMIT    = 40;
  localparam int          PLAN_LEN       = 24;

  localparam logic [INDEX_W-1:0] FIRST_SPARE_INDEX = INDEX_W'(REG_SWEEP_SHIFT) + 1'b1;
  localparam logic [3:0][7:0] DUTY_WAVES = {8'h7E, 8'h87, 8'h81, 8'h01};

  typedef enum logic {ROW_CMD, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    sqw_reg_t          reg_sel;
    logic [CFG_W-1:0]  data;
    sqw_cmd_t          op;
    logic [LEVEL_W-1:0] vol;
    logic              pinned;
    sqw_result_t       want;
  } plan_row_t;

  localparam sqw_result_t FREE = '0;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_CLOCK,   4'd15, 1'b1, '{4'd0, 1'b0, 11'd0}},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_SWEEP,   4'd15, 1'b1, '{4'd0, 1'b0, 11'd0}},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_LENGTH,  4'd0,  1'b1, '{4'd0, 1'b0, 11'd0}},
    '{ROW_WRITE, REG_DUTY_SELECT,    11'd3,    CMD_CLOCK,   4'd0,  1'b0, FREE},
    '{ROW_WRITE, REG_PERIOD_VALUE,   11'd2047, CMD_CLOCK,   4'd0,  1'b0, FREE},
    '{ROW_WRITE, REG_SWEEP_PERIOD,   11'd1,    CMD_CLOCK,   4'd0,  1'b0, FREE},
    '{ROW_WRITE, REG_SWEEP_SHIFT,    11'd0,    CMD_CLOCK,   4'd0,  1'b0, FREE},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_TRIGGER, 4'd9,  1'b1, '{4'd0, 1'b1, 11'd2047}},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_CLOCK,   4'd15, 1'b1, '{4'd0, 1'b1, 11'd2047}},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_CLOCK,   4'd15, 1'b1, '{4'd0, 1'b1, 11'd2047}},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_CLOCK,   4'd15, 1'b0, FREE},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_CLOCK,   4'd15, 1'b0, FREE},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_SWEEP,   4'd0,  1'b1, '{4'd15, 1'b0, 11'd2047}},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_TRIGGER, 4'd3,  1'b1, '{4'd15, 1'b1, 11'd2047}},
    '{ROW_WRITE, REG_SWEEP_DECREASE, 11'd1,    CMD_CLOCK,   4'd0,  1'b0, FREE},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_SWEEP,   4'd0,  1'b1, '{4'd15, 1'b1, 11'd0}},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_CLOCK,   4'd0,  1'b0, FREE},
    '{ROW_WRITE, REG_SWEEP_SHIFT,    11'd7,    CMD_CLOCK,   4'd0,  1'b0, FREE},
    '{ROW_WRITE, REG_SWEEP_PERIOD,   11'd7,    CMD_CLOCK,   4'd0,  1'b0, FREE},
    '{ROW_WRITE, REG_PERIOD_VALUE,   11'd0,    CMD_CLOCK,   4'd0,  1'b0, FREE},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_TRIGGER, 4'd0,  1'b1, '{4'd15, 1'b1, 11'd0}},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_SWEEP,   4'd0,  1'b0, FREE},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_LENGTH,  4'd15, 1'b0, FREE},
    '{ROW_CMD,   REG_DUTY_SELECT,    11'd0,    CMD_CLOCK,   4'd0,  1'b0, FREE}
  };

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [1:0]          cmd            = 2'd0;
  logic [LEVEL_W-1:0]  volume         = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [LEVEL_W-1:0]  sample;
  logic                active;
  logic [PERIOD_W-1:0] current_period;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [INDEX_W-1:0]  cfg_index      = '0;
  logic [CFG_W-1:0]    cfg_data       = '0;

  // channel model state and its register copy
  logic [PERIOD_W-1:0] tone_period  = '0;
  logic [TICK_W-1:0]   timer_count  = '0;
  logic [2:0]          duty_pos     = '0;
  logic [2:0]          sweep_count  = '0;
  logic                tone_on      = 1'b0;
  logic [LEVEL_W-1:0]  level        = '0;
  logic [1:0]          cfg_duty         = '0;
  logic [PERIOD_W-1:0] cfg_period       = '0;
  logic [2:0]          cfg_sweep_period = '0;
  logic                cfg_sweep_down   = 1'b0;
  logic [2:0]          cfg_sweep_shift  = '0;

  sqw_result_t pending_results [$];
  sqw_result_t pinned_want = '0;
  bit          pinned_on   = 1'b0;
  bit          send_gaps   = 1'b1;
  bit          recv_gaps   = 1'b1;
  int unsigned stall_left  = 0;
  int unsigned mismatches  = 0;
  int unsigned results_seen = 0;
  int unsigned writes_done = 0;
  int unsigned duty_steps  = 0;
  int unsigned sweep_stops = 0;
  int unsigned op_count [4] = '{0, 0, 0, 0};

  square_wave_channel_with_sweep #(.HAS_SWEEP(SWEEP_ON)) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .volume         (volume),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample         (sample),
    .active         (active),
    .current_period (current_period),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic flag_mismatch(input string what, input int unsigned seen,
                               input int unsigned wanted);
    if (mismatches < PRINT_LIMIT)
      $display("ERROR %0t: %s: got %0d, expected %0d", $realtime, what, seen, wanted);
    mismatches++;
  endtask

  task automatic load_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_DUTY_SELECT:    cfg_duty         = data[1:0];
      REG_PERIOD_VALUE:   cfg_period       = data[PERIOD_W-1:0];
      REG_SWEEP_PERIOD:   cfg_sweep_period = data[2:0];
      REG_SWEEP_DECREASE: cfg_sweep_down   = data[0];
      REG_SWEEP_SHIFT:    cfg_sweep_shift  = data[2:0];
      default: ;
    endcase
  endtask

  task automatic advance_channel(input sqw_cmd_t op, input logic [LEVEL_W-1:0] vol,
                                 output sqw_result_t res);
    int                  threshold;
    logic [PERIOD_W-1:0] delta;
    case (op)
      CMD_CLOCK: begin
        threshold   = (int'(PERIOD_BASE) - int'(tone_period)) * 4;
        timer_count = timer_count + 1'b1;
        if (int'(timer_count) >= threshold) begin
          duty_pos = duty_pos + 1'b1;
          if (tone_on && DUTY_WAVES[cfg_duty][3'd7 - duty_pos])
            level = vol;
          else
            level = '0;
          timer_count = timer_count - TICK_W'(threshold);
          duty_steps++;
        end
      end
      CMD_SWEEP: begin
        if (SWEEP_ON != 0 && cfg_sweep_period != 3'd0) begin
          if (sweep_count != cfg_sweep_period)
            sweep_count = sweep_count + 1'b1;
          if (sweep_count == cfg_sweep_period) begin
            delta = tone_period >> cfg_sweep_shift;
            if (!cfg_sweep_down && int'(tone_period) + int'(delta) > int'(PERIOD_LIMIT)) begin
              tone_on = 1'b0;
              sweep_stops++;
            end else begin
              tone_period = cfg_sweep_down ? tone_period - delta : tone_period + delta;
              timer_count = '0;
              sweep_count = '0;
            end
          end
        end
      end
      CMD_TRIGGER: begin
        tone_on     = 1'b1;
        tone_period = cfg_period;
        timer_count = '0;
        duty_pos    = '0;
        sweep_count = '0;
      end
      default: tone_on = 1'b0;
    endcase
    res.sample         = level;
    res.active         = tone_on;
    res.current_period = tone_period;
  endtask

  // check result transfers, then predict for the command transfer of this edge
  always @(posedge clk) begin
    sqw_result_t want;
    sqw_result_t predicted;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          flag_mismatch("result with nothing expected", sample, 0);
        end else begin
          want = pending_results.pop_front();
          if (sample !== want.sample)
            flag_mismatch("sample", sample, want.sample);
          if (active !== want.active)
            flag_mismatch("active", active, want.active);
          if (current_period !== want.current_period)
            flag_mismatch("current_period", current_period, want.current_period);
        end
      end
      if (cfg_valid && cfg_ready)
        load_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        op_count[cmd]++;
        advance_channel(sqw_cmd_t'(cmd), volume, predicted);
        pending_results.push_back(pinned_on ? pinned_want : predicted);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("square_wave_channel_with_sweep: mismatch");
    $finish;
  end

  task automatic push_cmd(input sqw_cmd_t op, input logic [LEVEL_W-1:0] vol,
                          input bit pin, input sqw_result_t want);
    int unsigned gap;
    gap = (send_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pinned_on   = pin;
    pinned_want = want;
    in_valid <= 1'b1;
    cmd      <= op;
    volume   <= vol;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    writes_done++;
  endtask

  // hold the sender until every expected result has arrived
  task automatic drain_results();
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic sqw_cmd_t random_cmd();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 72)
      return CMD_CLOCK;
    else if (pick < 84)
      return CMD_SWEEP;
    else if (pick < 93)
      return CMD_TRIGGER;
    return CMD_LENGTH;
  endfunction

  initial begin
    int unsigned      phase;
    int unsigned      n;
    int unsigned      pick;
    logic [CFG_W-1:0] period_pick;
    bit               quiet;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    for (int k = 0; k < PLAN_LEN; k++) begin
      if (plan[k].kind == ROW_WRITE) begin
        drain_results();
        write_reg(plan[k].reg_sel, plan[k].data);
      end else begin
        push_cmd(plan[k].op, plan[k].vol, plan[k].pinned, plan[k].want);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      quiet     = (phase >= PHASES - 2) || ($urandom_range(0, 4) == 0);
      send_gaps = !quiet;
      recv_gaps = !quiet;
      drain_results();
      pick = $urandom_range(0, 9);
      if (phase == 0)
        period_pick = CFG_W'(PERIOD_LIMIT);
      else if (phase == 1)
        period_pick = '0;
      else if (pick == 0)
        period_pick = CFG_W'($urandom_range(0, 2047));
      else if (pick == 1)
        period_pick = CFG_W'(PERIOD_LIMIT);
      else
        period_pick = CFG_W'($urandom_range(1984, 2047));
      if (phase == 0) begin
        write_reg(REG_DUTY_SELECT,    '1);
        write_reg(REG_SWEEP_PERIOD,   '1);
        write_reg(REG_SWEEP_DECREASE, '1);
        write_reg(REG_SWEEP_SHIFT,    '1);
      end else if (phase == 1) begin
        write_reg(REG_DUTY_SELECT,    '0);
        write_reg(REG_SWEEP_PERIOD,   '0);
        write_reg(REG_SWEEP_DECREASE, '0);
        write_reg(REG_SWEEP_SHIFT,    '0);
      end else begin
        write_reg(REG_DUTY_SELECT,    CFG_W'($urandom));
        write_reg(REG_SWEEP_PERIOD,   CFG_W'($urandom));
        write_reg(REG_SWEEP_DECREASE, CFG_W'($urandom));
        write_reg(REG_SWEEP_SHIFT,    CFG_W'($urandom));
      end
      write_reg(REG_PERIOD_VALUE, period_pick);
      if ($urandom_range(0, 2) == 0)
        write_reg(FIRST_SPARE_INDEX + INDEX_W'($urandom_range(0, 2)), CFG_W'($urandom));

      push_cmd(CMD_TRIGGER, LEVEL_W'($urandom_range(0, 15)), 1'b0, FREE);
      for (n = 1; n < PHASE_ITEMS; n++)
        push_cmd(random_cmd(), LEVEL_W'($urandom_range(0, 15)), 1'b0, FREE);
    end

    drain_results();
    repeat (4) @(negedge clk);
    $display("covered %0d clock, %0d sweep, %0d trigger, %0d length commands; %0d results",
             op_count[CMD_CLOCK], op_count[CMD_SWEEP], op_count[CMD_TRIGGER],
             op_count[CMD_LENGTH], results_seen);
    $display("%0d register writes, %0d duty advances, %0d sweep overflow stops",
             writes_done, duty_steps, sweep_stops);
    if (mismatches == 0)
      $display("square_wave_channel_with_sweep: match");
    else
      $display("square_wave_channel_with_sweep: mismatch");
    $finish;
  end

endmodule
